### hw/rtl/ptb_pkg.sv
// Shared types and constants for the periodic ticker bank.
`default_nettype none

package ptb_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_REPORTS = 16;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [3:0]         slot;
		logic [15:0]        start_delay;
		logic [15:0]        reload_value;
		logic signed [15:0] repeat_count;
		logic [15:0]        tag_in;
	} req_word_t;

	typedef struct packed {
		logic [3:0]  fired_slot;
		logic [15:0] fired_tag;
		logic        last;
	} rsp_word_t;

	typedef enum logic {
		OP_TICK,
		OP_LOAD
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic [3:0]         slot;
		logic [15:0]        delay;
		logic [15:0]        period;
		logic signed [15:0] count;
		logic [15:0]        tag;
	} op_t;

	typedef struct packed {
		logic [15:0]        delay;
		logic [15:0]        period;
		logic signed [15:0] count;
		logic [15:0]        tag;
	} slot_ent_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_WALK,
		EX_FLUSH
	} ex_state_t;

endpackage

`default_nettype wire

### hw/rtl/ptb_front.sv
// Front end: takes request words, drops out-of-range loads, forms operations.
`default_nettype none

module ptb_front #(
	parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
	input  wire                logic      clk,
	input  wire                logic      arst_n,
	input  wire                logic      req_valid,
	output logic                          req_ready,
	input  wire ptb_pkg::req_word_t       req,
	output logic                          op_valid,
	input  wire                logic      op_ready,
	output ptb_pkg::op_t                  op
);

	logic         op_valid_q;
	ptb_pkg::op_t op_q;
	logic         accept;
	logic         keep;

	assign req_ready = !op_valid_q || op_ready;
	assign accept    = req_valid && req_ready;
	// A load aimed past the last slot is taken and forgotten.
	assign keep      = (req.cmd == ptb_pkg::CMD_TICK) || (32'(req.slot) < SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_q <= 1'b0;
		end else if (accept) begin
			op_valid_q <= keep;
		end else if (op_ready) begin
			op_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.kind   <= (req.cmd == ptb_pkg::CMD_LOAD) ? ptb_pkg::OP_LOAD : ptb_pkg::OP_TICK;
			op_q.slot   <= req.slot;
			op_q.delay  <= req.start_delay;
			op_q.period <= req.reload_value;
			op_q.count  <= req.repeat_count;
			op_q.tag    <= req.tag_in;
		end
	end

	assign op_valid = op_valid_q;
	assign op       = op_q;

endmodule

`default_nettype wire

### hw/rtl/ptb_fifo.sv
// Short operation queue between the front end and the executor.
`default_nettype none

module ptb_fifo (
	input  wire                logic                    clk,
	input  wire                logic                    arst_n,
	input  wire                logic                    wr_valid,
	output logic                                        wr_ready,
	input  wire ptb_pkg::op_t                           wr_op,
	output logic                                        rd_valid,
	input  wire                logic                    rd_ready,
	output ptb_pkg::op_t                                rd_op,
	output logic [ptb_pkg::Q_CNT_W-1:0]                 level
);

	localparam int PW = ptb_pkg::Q_PTR_W;
	localparam int CW = ptb_pkg::Q_CNT_W;

	ptb_pkg::op_t   store_q [ptb_pkg::Q_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  level_q;
	logic           push;
	logic           pop;

	assign wr_ready = level_q != CW'(ptb_pkg::Q_DEPTH);
	assign rd_valid = level_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_op    = store_q[rd_ptr_q];
	assign level    = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(ptb_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(ptb_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ptb_exec.sv
// Executor: slot store, load writes, tick walk and the result register.
`default_nettype none

module ptb_exec #(
	parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
	input  wire                logic      clk,
	input  wire                logic      arst_n,
	input  wire                logic      op_valid,
	output logic                          op_ready,
	input  wire ptb_pkg::op_t             op,
	output logic                          rsp_valid,
	input  wire                logic      rsp_ready,
	output ptb_pkg::rsp_word_t            rsp
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int RPT_W = $clog2(ptb_pkg::MAX_REPORTS + 1);

	ptb_pkg::ex_state_t state_q;
	ptb_pkg::ex_state_t state_d;

	ptb_pkg::slot_ent_t ent_mem [SLOTS];
	logic [SLOTS-1:0]   vld_q;

	logic [CNT_W-1:0]   rd_cnt_q;
	logic [IDX_W-1:0]   rd_idx;
	logic               ex_valid_s1;
	logic [IDX_W-1:0]   ex_idx_s1;
	ptb_pkg::slot_ent_t ent_s1;
	logic               ent_vld_s1;

	logic               hold_valid_q;
	logic [3:0]         hold_slot_q;
	logic [15:0]        hold_tag_q;
	logic [RPT_W-1:0]   rep_cnt_q;

	logic               out_valid_q;
	ptb_pkg::rsp_word_t out_word_q;

	ptb_pkg::slot_ent_t cur;
	ptb_pkg::slot_ent_t upd;
	logic               fire;
	logic               report;
	logic               out_free;
	logic               walk_end;
	logic [IDX_W+3:0]   ld_ext;
	logic [IDX_W+3:0]   ex_ext;

	logic               start_tick;
	logic               advance;
	logic               issue;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	ptb_pkg::slot_ent_t wr_ent;
	logic               push_out;
	logic               push_last;
	logic               hold_load;

	assign rd_idx   = rd_cnt_q[IDX_W-1:0];
	assign ld_ext   = {{IDX_W{1'b0}}, op.slot};
	assign ex_ext   = {4'b0000, ex_idx_s1};
	assign out_free = !out_valid_q || rsp_ready;
	assign walk_end = (rd_cnt_q == CNT_W'(SLOTS)) && !ex_valid_s1;

	// Slot update for the entry in the execute stage.
	always_comb begin
		cur = ent_vld_s1 ? ent_s1 : '0;
		upd = cur;
		fire = 1'b0;
		if (cur.delay != 16'd0) begin
			upd.delay = cur.delay - 16'd1;
		end else if (cur.count != 16'sd0) begin
			fire = ex_valid_s1;
			upd.delay = cur.period;
			if (!cur.count[15]) begin
				upd.count = cur.count - 16'sd1;
			end
		end
		report = fire && (rep_cnt_q < RPT_W'(ptb_pkg::MAX_REPORTS));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptb_pkg::EX_IDLE: begin
				if (op_valid && op.kind == ptb_pkg::OP_TICK) begin
					state_d = ptb_pkg::EX_WALK;
				end
			end
			ptb_pkg::EX_WALK: begin
				if (walk_end) begin
					state_d = ptb_pkg::EX_FLUSH;
				end
			end
			ptb_pkg::EX_FLUSH: begin
				if (!hold_valid_q || out_free) begin
					state_d = ptb_pkg::EX_IDLE;
				end
			end
			default: state_d = ptb_pkg::EX_IDLE;
		endcase
	end

	always_comb begin
		op_ready   = 1'b0;
		start_tick = 1'b0;
		advance    = 1'b0;
		issue      = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = ex_idx_s1;
		wr_ent     = upd;
		push_out   = 1'b0;
		push_last  = 1'b0;
		hold_load  = 1'b0;
		unique case (state_q)
			ptb_pkg::EX_IDLE: begin
				op_ready   = 1'b1;
				start_tick = op_valid && op.kind == ptb_pkg::OP_TICK;
				if (op_valid && op.kind == ptb_pkg::OP_LOAD) begin
					wr_en         = 1'b1;
					wr_idx        = ld_ext[IDX_W-1:0];
					wr_ent.delay  = op.delay;
					wr_ent.period = op.period;
					wr_ent.count  = op.count;
					wr_ent.tag    = op.tag;
				end
			end
			ptb_pkg::EX_WALK: begin
				// A new firing pushes out the one held back, which is then known not last.
				advance   = !(report && hold_valid_q && !out_free);
				issue     = advance && (rd_cnt_q < CNT_W'(SLOTS));
				wr_en     = ex_valid_s1 && advance;
				push_out  = report && hold_valid_q && out_free;
				hold_load = report && advance;
			end
			ptb_pkg::EX_FLUSH: begin
				push_out  = hold_valid_q && out_free;
				push_last = 1'b1;
			end
			default: begin
				op_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptb_pkg::EX_IDLE;
			vld_q        <= '0;
			rd_cnt_q     <= '0;
			ex_valid_s1  <= 1'b0;
			hold_valid_q <= 1'b0;
			rep_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (start_tick) begin
				rd_cnt_q     <= '0;
				ex_valid_s1  <= 1'b0;
				hold_valid_q <= 1'b0;
				rep_cnt_q    <= '0;
			end else begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
				if (advance) begin
					ex_valid_s1 <= issue;
				end
				if (hold_load) begin
					hold_valid_q <= 1'b1;
					rep_cnt_q    <= rep_cnt_q + 1'b1;
				end else if (push_out && push_last) begin
					hold_valid_q <= 1'b0;
				end
			end
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[wr_idx] <= wr_ent;
		end
		if (issue) begin
			ent_s1     <= ent_mem[rd_idx];
			ent_vld_s1 <= vld_q[rd_idx];
			ex_idx_s1  <= rd_idx;
		end
		if (hold_load) begin
			hold_slot_q <= ex_ext[3:0];
			hold_tag_q  <= cur.tag;
		end
		if (push_out) begin
			out_word_q.fired_slot <= hold_slot_q;
			out_word_q.fired_tag  <= hold_tag_q;
			out_word_q.last       <= push_last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_word_q;

endmodule

`default_nettype wire

### hw/rtl/periodic_ticker_bank.sv
// Top level of the periodic ticker bank: front end, queue and executor.
//
// Usage: the request channel (req_valid, req_ready, req) carries one word per
// command. A load word (cmd set) writes one slot's start delay, reload period,
// repeat count and tag; a load to a slot at or past SLOTS is accepted and
// dropped, and a load produces no response. A tick word (cmd clear) walks all
// slots in index order and produces one response word per firing slot on the
// response channel (rsp_valid, rsp_ready, rsp), in slot order, with last set
// on the final word of that tick. A tick in which nothing fires gives nothing.
// A word passes through the front register and then the queue. In the
// executor a load is written from the idle state; a tick takes the operation,
// fills the read stage, reads the slot entries one by one from the slot store,
// sees the walk end and finally releases the held-back last result.
// Each firing is held until the next firing or the end of the walk, so the
// block knows which word is last. When the receiver stalls, the result
// register holds its word, the walk pauses on the next firing, and the queue
// keeps taking request words until it fills. Reset empties the queue and marks
// every slot entry as never written, which reads as all zero: every slot idle.
`default_nettype none

module periodic_ticker_bank #(
	parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
	input  wire                logic      clk,
	input  wire                logic      arst_n,
	input  wire                logic      req_valid,
	output logic                          req_ready,
	input  wire ptb_pkg::req_word_t       req,
	output logic                          rsp_valid,
	input  wire                logic      rsp_ready,
	output ptb_pkg::rsp_word_t            rsp
);

	logic                          f_valid;
	logic                          f_ready;
	ptb_pkg::op_t                  f_op;
	logic                          q_valid;
	logic                          q_ready;
	ptb_pkg::op_t                  q_op;
	logic [ptb_pkg::Q_CNT_W-1:0]   q_level;

	// Front end: takes words and turns them into tick or load operations.
	ptb_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op        (f_op)
	);

	// The queue lets the front keep taking words while a tick walk is stalled.
	ptb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_op    (f_op),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_op    (q_op),
		.level    (q_level)
	);

	// Executor: owns the slot store and the result register.
	ptb_exec #(
		.SLOTS (SLOTS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_valid),
		.op_ready  (q_ready),
		.op        (q_op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= ptb_pkg::Q_CNT_W'(ptb_pkg::Q_DEPTH))
		else $error("operation queue holds more than its depth");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (SLOTS > 16 || 32'(rsp.fired_slot) < SLOTS))
		else $error("response names a slot that does not exist");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> (q_level != '0))
		else $error("executor took an operation from an empty queue");
`endif

endmodule

`default_nettype wire
